// ===== rtl/b64u_pkg.sv =====
`default_nettype none

package b64u_pkg;

  // Pending bits plus one shifted-in byte at the largest pending count.
  localparam int unsigned ACC_W = 14;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned GRP_W = 6;
  // A byte on top of six pending bits gives two groups and a flush.
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 3'd6;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic             has_data;
    logic             bad_char;
    logic             end_of_run;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [GRP_W-1:0] value;
  } dec_t;

  // Maps a 6-bit group to its URL-safe alphabet character.
  function automatic logic [SYM_W-1:0] enc_char(input logic [GRP_W-1:0] v);
    logic [SYM_W-1:0] c;
    begin
      if (v < 6'd26) begin
        c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
        c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
        c = 8'h2D;
      end else begin
        c = 8'h5F;
      end
      return c;
    end
  endfunction

  // Maps an ASCII character back to its group value; valid is low outside
  // the alphabet.
  function automatic dec_t dec_char(input logic [SYM_W-1:0] c);
    dec_t d;
    begin
      d.valid = 1'b1;
      d.value = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
        d.value = GRP_W'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        d.value = GRP_W'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d.value = GRP_W'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2D) begin
        d.value = 6'd62;
      end else if (c == 8'h5F) begin
        d.value = 6'd63;
      end else begin
        d.valid = 1'b0;
      end
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64u_in_if.sv =====
`default_nettype none

interface b64u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_in;
  logic       is_last;

  modport source (output valid, output symbol_in, output is_last, input ready);
  modport sink (input valid, input symbol_in, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/b64u_out_if.sv =====
`default_nettype none

interface b64u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_out;
  logic       has_data;
  logic       bad_char;
  logic       end_of_run;

  modport source (output valid, output symbol_out, output has_data, output bad_char,
                  output end_of_run, input ready);
  modport sink (input valid, input symbol_out, input has_data, input bad_char,
                input end_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/base64url_lsb_first_codec_unit.sv =====
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    symbol_in[7:0], is_last
// out_ch    out  valid/ready    symbol_out[7:0], has_data, bad_char, end_of_run
// cfg       in   cfg_wr_en      cfg_wr_data (direction)
//
// An item is taken when the result buffer is free; its results are
// registered into the buffer and leave at one per cycle while the output
// is ready. An item gives 0..2 results, up to 3 after an unusual state.
// The single output port of the result buffer sets that rate.
// Reset is synchronous and active low; it clears direction, pending state
// and the buffer. A stalled output holds its result; the input is taken in
// the same cycle that the last buffered result leaves.
module base64url_lsb_first_codec_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  b64u_in_if.sink   in_ch,
  b64u_out_if.source out_ch,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);
  import b64u_pkg::*;

  logic                 direction_r;
  logic [GRP_W-1:0]     pend_bits_r, pend_bits_nxt;
  logic [CNT_W-1:0]     pend_cnt_r, pend_cnt_nxt;

  res_t                 res_r [MAX_RES];
  res_t                 res_nxt [MAX_RES];
  logic [RES_IDX_W-1:0] num_r, num_nxt;
  logic [RES_IDX_W-1:0] rd_idx_r;

  logic                 in_take, out_take, buf_free;
  res_t                 head;

  logic [CNT_W-1:0]     cnt_c;
  logic [ACC_W-1:0]     acc_pb;

  // Encode path signals.
  logic [ACC_W-1:0]     acc_e, acc_e2;
  logic [3:0]           cnt_e, cnt_e2;
  logic                 two_grp, flush;
  logic [SYM_W-1:0]     chr0, chr1, chr_fl;

  // Decode path signals.
  dec_t                 dv;
  logic [ACC_W-1:0]     acc_d;
  logic [3:0]           cnt_d;

  // Buffer read side.
  assign out_ch.valid = (rd_idx_r != num_r);
  assign out_take     = out_ch.valid && out_ch.ready;
  assign buf_free     = !out_ch.valid || (out_take && (rd_idx_r + 2'd1 == num_r));
  assign in_ch.ready  = buf_free;
  assign in_take      = in_ch.valid && buf_free;

  always_comb begin
    case (rd_idx_r)
      2'd1:    head = res_r[1];
      2'd2:    head = res_r[2];
      default: head = res_r[0];
    endcase
  end

  assign out_ch.symbol_out = head.symbol_out;
  assign out_ch.has_data   = head.has_data;
  assign out_ch.bad_char   = head.bad_char;
  assign out_ch.end_of_run = head.end_of_run;

  // Pending state is used as stored; the count is clamped to six.
  assign cnt_c  = (pend_cnt_r > CNT_MAX) ? CNT_MAX : pend_cnt_r;
  assign acc_pb = {{(ACC_W-GRP_W){1'b0}}, pend_bits_r};

  // Encode: the byte lands above the pending bits, groups leave lowest first.
  assign acc_e   = acc_pb | ({{(ACC_W-SYM_W){1'b0}}, in_ch.symbol_in} << cnt_c);
  assign cnt_e   = {1'b0, cnt_c} + 4'd8;
  assign two_grp = (cnt_e >= 4'd12);
  assign acc_e2  = two_grp ? (acc_e >> 12) : (acc_e >> 6);
  assign cnt_e2  = two_grp ? (cnt_e - 4'd12) : (cnt_e - 4'd6);
  assign flush   = in_ch.is_last && (cnt_e2 != 4'd0);
  assign chr0    = enc_char(acc_e[5:0]);
  assign chr1    = enc_char(acc_e[11:6]);
  assign chr_fl  = enc_char(acc_e2[5:0]);

  // Decode: a valid character adds six bits; a byte leaves once eight are in.
  assign dv    = dec_char(in_ch.symbol_in);
  assign acc_d = acc_pb | ({{(ACC_W-GRP_W){1'b0}}, dv.value} << cnt_c);
  assign cnt_d = {1'b0, cnt_c} + 4'd6;

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_nxt[i] = '0;
    end
    num_nxt       = '0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;

    if (direction_r == DIR_ENCODE) begin
      res_nxt[0].symbol_out = chr0;
      res_nxt[0].has_data   = 1'b1;
      if (two_grp) begin
        res_nxt[1].symbol_out = chr1;
        res_nxt[1].has_data   = 1'b1;
        if (flush) begin
          res_nxt[2].symbol_out = chr_fl;
          res_nxt[2].has_data   = 1'b1;
          res_nxt[2].end_of_run = 1'b1;
          num_nxt = 2'd3;
        end else begin
          res_nxt[1].end_of_run = in_ch.is_last;
          num_nxt = 2'd2;
        end
      end else begin
        if (flush) begin
          res_nxt[1].symbol_out = chr_fl;
          res_nxt[1].has_data   = 1'b1;
          res_nxt[1].end_of_run = 1'b1;
          num_nxt = 2'd2;
        end else begin
          res_nxt[0].end_of_run = in_ch.is_last;
          num_nxt = 2'd1;
        end
      end
      pend_bits_nxt = acc_e2[GRP_W-1:0];
      pend_cnt_nxt  = cnt_e2[CNT_W-1:0];
    end else begin
      if (!dv.valid) begin
        // A bad character is skipped; only an error result is given.
        res_nxt[0].bad_char   = 1'b1;
        res_nxt[0].end_of_run = in_ch.is_last;
        num_nxt = 2'd1;
      end else if (cnt_d >= 4'd8) begin
        res_nxt[0].symbol_out = acc_d[7:0];
        res_nxt[0].has_data   = 1'b1;
        res_nxt[0].end_of_run = in_ch.is_last;
        num_nxt       = 2'd1;
        pend_bits_nxt = acc_d[13:8];
        pend_cnt_nxt  = CNT_W'(cnt_d - 4'd8);
      end else begin
        // No full byte yet; the last character still closes the string.
        res_nxt[0].end_of_run = 1'b1;
        num_nxt       = in_ch.is_last ? 2'd1 : 2'd0;
        pend_bits_nxt = acc_d[GRP_W-1:0];
        pend_cnt_nxt  = cnt_d[CNT_W-1:0];
      end
    end

    if (in_ch.is_last) begin
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      num_r       <= '0;
      rd_idx_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        direction_r <= cfg_wr_data;
        pend_bits_r <= '0;
        pend_cnt_r  <= '0;
      end else if (in_take) begin
        pend_bits_r <= pend_bits_nxt;
        pend_cnt_r  <= pend_cnt_nxt;
      end
      if (in_take) begin
        num_r    <= num_nxt;
        rd_idx_r <= '0;
      end else if (out_take) begin
        rd_idx_r <= rd_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/b64u_result_checker.sv =====
module b64u_result_checker
  import b64u_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  b64u_in_if          in_mon,
  b64u_out_if         out_mon,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  output int unsigned fail_count,
  output int unsigned awaited,
  output int unsigned matched
);
  timeunit 1ns;
  timeprecision 1ps;

  // Alphabet in value order; the first character sits in the top byte.
  localparam logic [8*64-1:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic        mode_q = DIR_ENCODE;
  logic [5:0]  carry_bits = '0;
  int unsigned carry_count = 0;
  res_t        expected_results[$];
  int unsigned errs = 0;
  int unsigned n_checked = 0;

  function automatic logic [7:0] char_of_group(input logic [5:0] g);
    return URL_ALPHABET[8*(63-int'(g)) +: 8];
  endfunction

  // Group value of a character, or -1 when it is outside the alphabet.
  function automatic int group_of_char(input logic [7:0] c);
    int ci;
    ci = int'(c);
    if (ci >= "A" && ci <= "Z") return ci - "A";
    if (ci >= "a" && ci <= "z") return ci - "a" + 26;
    if (ci >= "0" && ci <= "9") return ci - "0" + 52;
    if (ci == "-") return 62;
    if (ci == "_") return 63;
    return -1;
  endfunction

  // Works out the results of one item and advances the carried bits.
  function automatic void predict_codec_results(input logic [7:0] sym, input logic last);
    logic [13:0] bits;
    int unsigned cnt;
    int          grp;
    res_t        outs[3];
    int          n;
    bits = {8'b0, carry_bits};
    cnt  = carry_count;
    n    = 0;
    for (int i = 0; i < 3; i++) outs[i] = '0;
    if (mode_q == DIR_ENCODE) begin
      bits = bits | (14'(sym) << cnt);
      cnt += 8;
      while (cnt >= 6) begin
        outs[n].symbol_out = char_of_group(bits[5:0]);
        outs[n].has_data   = 1'b1;
        n++;
        bits = bits >> 6;
        cnt -= 6;
      end
      if (last && cnt > 0) begin
        outs[n].symbol_out = char_of_group(bits[5:0]);
        outs[n].has_data   = 1'b1;
        n++;
      end
      if (last) begin
        outs[n-1].end_of_run = 1'b1;
        bits = '0;
        cnt  = 0;
      end
    end else begin
      grp = group_of_char(sym);
      if (grp < 0) begin
        // A bad character is skipped and leaves the carried bits alone.
        outs[0].bad_char   = 1'b1;
        outs[0].end_of_run = last;
        n = 1;
      end else begin
        bits = bits | (14'(grp) << cnt);
        cnt += 6;
        if (cnt >= 8) begin
          outs[0].symbol_out = bits[7:0];
          outs[0].has_data   = 1'b1;
          outs[0].end_of_run = last;
          n = 1;
          bits = bits >> 8;
          cnt -= 8;
        end else if (last) begin
          outs[0].end_of_run = 1'b1;
          n = 1;
        end
      end
      if (last) begin
        bits = '0;
        cnt  = 0;
      end
    end
    carry_bits  = bits[5:0];
    carry_count = cnt;
    for (int i = 0; i < n; i++) expected_results.push_back(outs[i]);
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      mode_q      = DIR_ENCODE;
      carry_bits  = '0;
      carry_count = 0;
      expected_results.delete();
    end else begin
      // Results are compared before this edge's item is predicted, since an
      // item's results never leave in the cycle it is taken.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("Unexpected result: symbol_out 0x%0h has_data %0b bad_char %0b end_of_run %0b",
                 out_mon.symbol_out, out_mon.has_data, out_mon.bad_char, out_mon.end_of_run);
          errs++;
        end else begin
          want = expected_results.pop_front();
          check_field("symbol_out", want.symbol_out, out_mon.symbol_out);
          check_field("has_data", want.has_data, out_mon.has_data);
          check_field("bad_char", want.bad_char, out_mon.bad_char);
          check_field("end_of_run", want.end_of_run, out_mon.end_of_run);
          n_checked++;
        end
      end
      if (cfg_wr_en) begin
        mode_q      = cfg_wr_data;
        carry_bits  = '0;
        carry_count = 0;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_codec_results(in_mon.symbol_in, in_mon.is_last);
      end
    end
    fail_count <= errs;
    awaited    <= expected_results.size();
    matched    <= n_checked;
  end

endmodule

// ===== verif/base64url_lsb_first_codec_unit_tb.sv =====
module base64url_lsb_first_codec_unit_tb;
  import b64u_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Random items are sent until this many items in total have gone in.
  localparam int unsigned ITEM_GOAL = 1550;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  b64u_in_if  in_ch ();
  b64u_out_if out_ch ();

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned matched;

  // Stimulus bookkeeping, used for pacing and for the closing summary.
  int unsigned items_sent = 0;
  int unsigned runs_sent  = 0;
  int unsigned dir_writes = 0;
  bit          tx_calm    = 1'b0;
  logic [7:0]  run_buf[$];

  base64url_lsb_first_codec_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // The checker watches both channels and the register port on its own; the
  // top only produces stimulus and reads back the totals for the verdict.
  b64u_result_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .awaited    (awaited),
    .matched    (matched)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offers one item after a random gap and holds it until the block takes it.
  // When the next gap is zero, valid simply stays high into the next item, so
  // valid never gets two assignments in one time step.
  task automatic offer_item(input logic [7:0] sym, input logic last);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.symbol_in <= sym;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Sends the elements in run_buf as one string. A string left open has no
  // final marker, which models a stream cut off by a mode change.
  task automatic send_run(input bit close);
    for (int i = 0; i < run_buf.size(); i++) begin
      offer_item(run_buf[i], close && (i == run_buf.size() - 1));
    end
    if (close) runs_sent++;
  endtask

  // Mostly characters of the alphabet, with some arbitrary bytes mixed in so
  // that bad characters show up inside otherwise valid strings.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'("A" + $urandom_range(0, 25));
      1: return 8'("a" + $urandom_range(0, 25));
      2: return 8'("0" + $urandom_range(0, 9));
      default: return $urandom_range(0, 1) ? 8'("-") : 8'("_");
    endcase
  endfunction

  task automatic fill_run(input logic mode, input int unsigned len);
    run_buf.delete();
    repeat (len) begin
      if (mode == DIR_ENCODE) begin
        run_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        run_buf.push_back(pick_char());
      end
    end
  endtask

  // Waits until every predicted result has left the block. A decode item
  // that yields nothing may still be in flight at that point, so the task
  // waits longer before the block is treated as idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The mode register is only written while the block is idle.
  task automatic set_direction(input logic mode);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dir_writes++;
  endtask

  // Result side. Each result waits a random stall, some stretches take
  // results at full rate, and twice the receiver holds off for a long time so
  // the result buffer fills and the block pushes back on its input.
  initial begin
    int unsigned n_taken;
    int unsigned stall;
    bit          rx_calm;
    n_taken = 0;
    rx_calm = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n_taken % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (n_taken == 300 || n_taken == 1200) begin
        stall = 250;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 13);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n_taken++;
    end
  end

  // Main stimulus: reset, a directed set of strings in both modes, then
  // random phases, each with its own mode and pacing.
  initial begin
    logic        phase_dir;
    int unsigned phase_end;
    int unsigned len;
    int unsigned pick;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.symbol_in <= 8'h00;
    in_ch.is_last   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encoding. A lone zero byte and a lone all-ones byte each give one
    // character and a flush. Three bytes end on a group boundary, so the last
    // byte gives two characters and no flush. Two bytes leave four bits for
    // the flush, and four bytes walk the carry through every count.
    set_direction(DIR_ENCODE);
    run_buf = '{8'h00};
    send_run(1'b1);
    run_buf = '{8'hFF};
    send_run(1'b1);
    run_buf = '{8'hFF, 8'h00, 8'hFF};
    send_run(1'b1);
    run_buf = '{8'hA5, 8'h5A};
    send_run(1'b1);
    run_buf = '{8'h80, 8'h01, 8'h7F, 8'hFE};
    send_run(1'b1);

    // Decoding. One character on its own is too short for a byte, so only an
    // end marker comes back. The alphabet's last two characters and 'z'
    // finish a byte on the final character. NUL and 0xFF are bad characters,
    // the second one at the end of a string holding pending bits, as is '/'
    // after the standard-alphabet '+'. The last string produces a byte on each
    // of its last three characters.
    set_direction(DIR_DECODE);
    run_buf = '{"A"};
    send_run(1'b1);
    run_buf = '{"_", "-", "z"};
    send_run(1'b1);
    run_buf = '{"a", 8'h00, "9", 8'hFF};
    send_run(1'b1);
    run_buf = '{"Z", "0", "+", "/"};
    send_run(1'b1);
    run_buf = '{"Q", "w", "E", "r"};
    send_run(1'b1);

    // Random phases. Strings are mostly short with a few long ones; now and
    // then a phase ends on an unfinished string, which the next mode write
    // discards.
    while (items_sent < ITEM_GOAL) begin
      phase_dir = $urandom_range(0, 1) ? DIR_DECODE : DIR_ENCODE;
      set_direction(phase_dir);
      tx_calm   = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(40, 160);
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) begin
          len = $urandom_range(1, 8);
        end else if (pick < 19) begin
          len = $urandom_range(9, 24);
        end else begin
          len = $urandom_range(25, 60);
        end
        fill_run(phase_dir, len);
        send_run(1'b1);
      end
      if ($urandom_range(0, 3) == 0) begin
        fill_run(phase_dir, $urandom_range(1, 3));
        send_run(1'b0);
      end
    end

    drain_results();
    $display("Sent %0d items in %0d complete strings across %0d mode writes,",
             items_sent, runs_sent, dir_writes);
    $display("and compared %0d results field by field.", matched);
    if (fail_count == 0 && awaited == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, several times longer than the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still awaited", awaited);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/b64u_pkg.sv
rtl/b64u_in_if.sv
rtl/b64u_out_if.sv
rtl/base64url_lsb_first_codec_unit.sv
verif/b64u_result_checker.sv
verif/base64url_lsb_first_codec_unit_tb.sv
